FILE: hdl/ascii_sensor_frame_distance_assert.svh
// Assertion macros for the ascii_sensor_frame_distance checker.
// Expects signals named clock and reset in the scope of use.
`ifndef ASCII_SENSOR_FRAME_DISTANCE_ASSERT_SVH
`define ASCII_SENSOR_FRAME_DISTANCE_ASSERT_SVH

// checked outside reset only
`define ASFD_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define ASFD_CHECK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hdl/asfd_pkg.sv
// Shared types and constants for the ascii_sensor_frame_distance block.
// No dependencies.
package asfd_pkg;

   localparam int BYTE_W  = 8;
   localparam int CH_W    = 1;
   localparam int DIST_W  = 24;
   localparam int RAW_W   = 16;
   localparam int CAL_W   = 10;
   localparam int ND_W    = 8;
   localparam int APB_DW  = 32;
   localparam int APB_AW  = 5;

   localparam int DIV_STEPS = DIST_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam logic [BYTE_W-1:0] ASCII_LF   = 8'd10;
   localparam logic [BYTE_W-1:0] ASCII_CR   = 8'd13;
   localparam logic signed [RAW_W-1:0] ASCII_ZERO = 16'sd48;
   localparam logic signed [RAW_W-1:0] HUNDRED    = 16'sd100;
   localparam logic signed [RAW_W-1:0] TEN        = 16'sd10;

   localparam logic [ND_W-1:0]  NEAR_DIST_RST = 8'd10;
   localparam logic [ND_W-1:0]  FAR_DIST_RST  = 8'd50;
   localparam logic [CAL_W-1:0] CAL_RAW_RST   = 10'd0;
   localparam logic [CAL_W-1:0] LIMIT_RST     = 10'd700;

   typedef enum logic [2:0] {
      REG_NEAR_DIST  = 3'd0,
      REG_FAR_DIST   = 3'd1,
      REG_NEAR_RAW0  = 3'd2,
      REG_FAR_RAW0   = 3'd3,
      REG_NEAR_RAW1  = 3'd4,
      REG_FAR_RAW1   = 3'd5,
      REG_LIMIT0     = 3'd6,
      REG_LIMIT1     = 3'd7
   } reg_idx_type;

endpackage

FILE: hdl/asfd_ifs.sv
// Valid/ready channel interfaces for the request and response transactions.
// Depends on asfd_pkg.
interface asfd_req_if;
   logic                          valid;
   logic                          ready;
   logic [asfd_pkg::BYTE_W-1:0]   rx_byte;
   logic [asfd_pkg::CH_W-1:0]     channel;

   modport source (output valid, output rx_byte, output channel, input ready);
   modport sink   (input valid, input rx_byte, input channel, output ready);
endinterface

interface asfd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [asfd_pkg::DIST_W-1:0]  distance;
   logic signed [asfd_pkg::RAW_W-1:0]   raw_reading;
   logic [asfd_pkg::CH_W-1:0]           channel_out;
   logic                                cal_error;

   modport source (output valid, output distance, output raw_reading, output channel_out,
                   output cal_error, input ready);
   modport sink   (input valid, input distance, input raw_reading, input channel_out,
                   input cal_error, output ready);
endinterface

FILE: hdl/ascii_sensor_frame_distance.sv
// Top level: ASCII sensor frame decoder with two-point linear calibration.
// Depends on asfd_pkg and the channel interfaces in asfd_ifs.sv.
//
// Usage:
//   req_bus carries one received serial byte per transaction plus the channel
//   select. Bytes that do not complete a frame only shift the window and
//   leave the block ready for the next byte. A byte that completes a frame
//   (second-oldest byte of the window is LF) yields a reading and clears the
//   window; if the reading is below the channel limit a response transaction
//   follows on rsp_bus, otherwise nothing is sent. Mapping uses one 17x10
//   multiplier three times, a sign step, a 24-step restoring divider with one
//   subtractor and a final sign fix, each in its own registered state, before
//   rsp_bus.valid is raised; the next byte is taken only after the response
//   is accepted. Equal calibration raws skip the arithmetic: the response
//   comes in the next cycle with cal_error set and distance 0.
//   req_bus.ready is low while a frame is being mapped and while a response
//   waits; a stalled receiver holds the response and the block stays busy.
//   Registers are written over the APB port, by the user only while idle:
//   wr_en ignores the state. pready is always high. Reset (synchronous) clears
//   the window, loads register defaults and drops any transaction in flight.
module ascii_sensor_frame_distance (
   input  logic                            clock,
   input  logic                            reset,
   asfd_req_if.sink                        req_bus,
   asfd_rsp_if.source                      rsp_bus,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [asfd_pkg::APB_AW-1:0]     paddr,
   input  logic [asfd_pkg::APB_DW-1:0]     pwdata,
   output logic [asfd_pkg::APB_DW-1:0]     prdata,
   output logic                            pready
);

   typedef enum logic [2:0] {
      S_IDLE, S_MUL_A, S_MUL_B, S_MUL_C, S_ABS, S_DIV, S_SIGN, S_OUT
   } state_type;

   // configuration registers
   logic [asfd_pkg::ND_W-1:0]  near_dist_ff, far_dist_ff;
   logic [asfd_pkg::CAL_W-1:0] near_raw0_ff, far_raw0_ff, near_raw1_ff, far_raw1_ff;
   logic [asfd_pkg::CAL_W-1:0] limit0_ff, limit1_ff;
   logic                       wr_en;
   asfd_pkg::reg_idx_type      reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_idx = asfd_pkg::reg_idx_type'(paddr[asfd_pkg::APB_AW-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         near_dist_ff <= asfd_pkg::NEAR_DIST_RST;
         far_dist_ff  <= asfd_pkg::FAR_DIST_RST;
         near_raw0_ff <= asfd_pkg::CAL_RAW_RST;
         far_raw0_ff  <= asfd_pkg::CAL_RAW_RST;
         near_raw1_ff <= asfd_pkg::CAL_RAW_RST;
         far_raw1_ff  <= asfd_pkg::CAL_RAW_RST;
         limit0_ff    <= asfd_pkg::LIMIT_RST;
         limit1_ff    <= asfd_pkg::LIMIT_RST;
      end else if (wr_en) begin
         unique case (reg_idx)
            asfd_pkg::REG_NEAR_DIST: near_dist_ff <= pwdata[asfd_pkg::ND_W-1:0];
            asfd_pkg::REG_FAR_DIST:  far_dist_ff  <= pwdata[asfd_pkg::ND_W-1:0];
            asfd_pkg::REG_NEAR_RAW0: near_raw0_ff <= pwdata[asfd_pkg::CAL_W-1:0];
            asfd_pkg::REG_FAR_RAW0:  far_raw0_ff  <= pwdata[asfd_pkg::CAL_W-1:0];
            asfd_pkg::REG_NEAR_RAW1: near_raw1_ff <= pwdata[asfd_pkg::CAL_W-1:0];
            asfd_pkg::REG_FAR_RAW1:  far_raw1_ff  <= pwdata[asfd_pkg::CAL_W-1:0];
            asfd_pkg::REG_LIMIT0:    limit0_ff    <= pwdata[asfd_pkg::CAL_W-1:0];
            asfd_pkg::REG_LIMIT1:    limit1_ff    <= pwdata[asfd_pkg::CAL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_idx)
         asfd_pkg::REG_NEAR_DIST: prdata = {24'd0, near_dist_ff};
         asfd_pkg::REG_FAR_DIST:  prdata = {24'd0, far_dist_ff};
         asfd_pkg::REG_NEAR_RAW0: prdata = {22'd0, near_raw0_ff};
         asfd_pkg::REG_FAR_RAW0:  prdata = {22'd0, far_raw0_ff};
         asfd_pkg::REG_NEAR_RAW1: prdata = {22'd0, near_raw1_ff};
         asfd_pkg::REG_FAR_RAW1:  prdata = {22'd0, far_raw1_ff};
         asfd_pkg::REG_LIMIT0:    prdata = {22'd0, limit0_ff};
         asfd_pkg::REG_LIMIT1:    prdata = {22'd0, limit1_ff};
         default:                 prdata = '0;
      endcase
   end

   // datapath state
   state_type                          state_ff, state_in;
   logic [asfd_pkg::BYTE_W-1:0]        win_ff [4];
   logic [asfd_pkg::BYTE_W-1:0]        win_in [4];
   logic signed [asfd_pkg::RAW_W-1:0]  x_ff, x_in;
   logic [asfd_pkg::CH_W-1:0]          ch_ff, ch_in;
   logic [asfd_pkg::CAL_W-1:0]         nr_ff, nr_in, fr_ff, fr_in;
   logic                               err_ff, err_in;
   logic signed [asfd_pkg::DIST_W-1:0] acc_ff, acc_in;
   logic [asfd_pkg::DIST_W-1:0]        dvd_ff, dvd_in;
   logic [asfd_pkg::CAL_W-1:0]         rem_ff, rem_in, den_ff, den_in;
   logic                               qneg_ff, qneg_in;
   logic [asfd_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [asfd_pkg::DIST_W-1:0] dist_ff, dist_in;

   // frame decode
   logic                               frame, lf_cr_lf, below_limit;
   logic signed [asfd_pkg::RAW_W-1:0]  d1, d2, d3, x_new;
   logic [asfd_pkg::CAL_W-1:0]         sel_nr, sel_fr, sel_limit;

   assign frame    = (win_ff[1] == asfd_pkg::ASCII_LF);
   assign lf_cr_lf = (win_ff[3] == asfd_pkg::ASCII_CR) && (req_bus.rx_byte == asfd_pkg::ASCII_LF);
   assign d1       = $signed({8'd0, win_ff[2]}) - asfd_pkg::ASCII_ZERO;
   assign d2       = $signed({8'd0, win_ff[3]}) - asfd_pkg::ASCII_ZERO;
   assign d3       = $signed({8'd0, req_bus.rx_byte}) - asfd_pkg::ASCII_ZERO;
   assign x_new    = lf_cr_lf ? '0 : (d1 * asfd_pkg::HUNDRED + d2 * asfd_pkg::TEN + d3);
   assign sel_nr    = req_bus.channel[0] ? near_raw1_ff : near_raw0_ff;
   assign sel_fr    = req_bus.channel[0] ? far_raw1_ff  : far_raw0_ff;
   assign sel_limit = req_bus.channel[0] ? limit1_ff    : limit0_ff;
   assign below_limit = (x_new < $signed({6'd0, sel_limit}));

   // shared multiplier
   logic signed [16:0] mul_a;
   logic signed [9:0]  mul_b;
   logic signed [26:0] prod;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_MUL_A: begin
            mul_a = 17'(x_ff);
            mul_b = $signed({2'd0, near_dist_ff}) - $signed({2'd0, far_dist_ff});
         end
         S_MUL_B: begin
            mul_a = $signed({7'd0, nr_ff});
            mul_b = $signed({2'd0, far_dist_ff});
         end
         S_MUL_C: begin
            mul_a = $signed({7'd0, fr_ff});
            mul_b = $signed({2'd0, near_dist_ff});
         end
         default: ;
      endcase
   end

   assign prod = mul_a * mul_b;

   // shared subtractor for the divider
   logic [asfd_pkg::CAL_W:0] rem_shift, trial;
   logic signed [asfd_pkg::CAL_W:0] den_s;

   assign rem_shift = {rem_ff, dvd_ff[asfd_pkg::DIST_W-1]};
   assign trial     = rem_shift - {1'b0, den_ff};
   assign den_s     = $signed({1'b0, nr_ff}) - $signed({1'b0, fr_ff});

   always_comb begin
      state_in = state_ff;
      win_in   = win_ff;
      x_in     = x_ff;
      ch_in    = ch_ff;
      nr_in    = nr_ff;
      fr_in    = fr_ff;
      err_in   = err_ff;
      acc_in   = acc_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      qneg_in  = qneg_ff;
      cnt_in   = cnt_ff;
      dist_in  = dist_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               win_in[0] = win_ff[1];
               win_in[1] = win_ff[2];
               win_in[2] = win_ff[3];
               win_in[3] = req_bus.rx_byte;
               if (frame) begin
                  win_in = '{default: '0};
                  if (below_limit) begin
                     x_in  = x_new;
                     ch_in = req_bus.channel;
                     nr_in = sel_nr;
                     fr_in = sel_fr;
                     if (sel_nr == sel_fr) begin
                        err_in   = 1'b1;
                        dist_in  = '0;
                        state_in = S_OUT;
                     end else begin
                        err_in   = 1'b0;
                        state_in = S_MUL_A;
                     end
                  end
               end
            end
         end
         S_MUL_A: begin
            acc_in   = prod[asfd_pkg::DIST_W-1:0];
            state_in = S_MUL_B;
         end
         S_MUL_B: begin
            acc_in   = acc_ff + prod[asfd_pkg::DIST_W-1:0];
            state_in = S_MUL_C;
         end
         S_MUL_C: begin
            acc_in   = acc_ff - prod[asfd_pkg::DIST_W-1:0];
            state_in = S_ABS;
         end
         S_ABS: begin
            dvd_in   = acc_ff[asfd_pkg::DIST_W-1] ? 24'(-acc_ff) : 24'(acc_ff);
            den_in   = den_s[asfd_pkg::CAL_W] ? 10'(-den_s) : den_s[asfd_pkg::CAL_W-1:0];
            qneg_in  = acc_ff[asfd_pkg::DIST_W-1] ^ den_s[asfd_pkg::CAL_W];
            rem_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (!trial[asfd_pkg::CAL_W]) begin
               rem_in = trial[asfd_pkg::CAL_W-1:0];
               dvd_in = {dvd_ff[asfd_pkg::DIST_W-2:0], 1'b1};
            end else begin
               rem_in = rem_shift[asfd_pkg::CAL_W-1:0];
               dvd_in = {dvd_ff[asfd_pkg::DIST_W-2:0], 1'b0};
            end
            if (cnt_ff == asfd_pkg::CNT_W'(asfd_pkg::DIV_STEPS - 1)) begin
               state_in = S_SIGN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_SIGN: begin
            dist_in  = qneg_ff ? -$signed(dvd_ff) : $signed(dvd_ff);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_bus.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         win_ff   <= '{default: '0};
      end else begin
         state_ff <= state_in;
         win_ff   <= win_in;
      end
      x_ff    <= x_in;
      ch_ff   <= ch_in;
      nr_ff   <= nr_in;
      fr_ff   <= fr_in;
      err_ff  <= err_in;
      acc_ff  <= acc_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      qneg_ff <= qneg_in;
      cnt_ff  <= cnt_in;
      dist_ff <= dist_in;
   end

   assign req_bus.ready       = (state_ff == S_IDLE);
   assign rsp_bus.valid       = (state_ff == S_OUT);
   assign rsp_bus.distance    = dist_ff;
   assign rsp_bus.raw_reading = x_ff;
   assign rsp_bus.channel_out = ch_ff;
   assign rsp_bus.cal_error   = err_ff;

endmodule

FILE: hdl/asfd_checker.sv
// Port-level checker for ascii_sensor_frame_distance, bound to the top level.
// Depends on asfd_pkg and ascii_sensor_frame_distance_assert.svh.
`include "ascii_sensor_frame_distance_assert.svh"

module asfd_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [asfd_pkg::DIST_W-1:0]  distance,
   input logic signed [asfd_pkg::RAW_W-1:0]   raw_reading,
   input logic [asfd_pkg::CH_W-1:0]           channel_out,
   input logic                                cal_error
);

   logic                                                         rsp_stall;
   logic [asfd_pkg::DIST_W+asfd_pkg::RAW_W+asfd_pkg::CH_W:0]     payload;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign payload   = {distance, raw_reading, channel_out, cal_error};

   `ASFD_CHECK_ALWAYS(a_reset_idle, reset |=> (req_ready && !rsp_valid), "not idle after reset")

   `ASFD_CHECK(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(payload), "held response changed")

   `ASFD_CHECK(a_cal_err_zero, (rsp_valid && cal_error) |-> (distance == '0), "cal_error with distance")

   `ASFD_CHECK(a_busy_with_rsp, rsp_valid |-> !req_ready, "request taken while a response is pending")

endmodule

bind ascii_sensor_frame_distance asfd_checker u_asfd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .distance    (rsp_bus.distance),
   .raw_reading (rsp_bus.raw_reading),
   .channel_out (rsp_bus.channel_out),
   .cal_error   (rsp_bus.cal_error)
);
